// File: sv/quaternary_ir_frame_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef QUATERNARY_IR_FRAME_DECODER_ASSERT_SVH
`define QUATERNARY_IR_FRAME_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is high.
`define QIRD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define QIRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QIRD_ASSERT(lbl, clk, rst, prop, msg)
`define QIRD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: sv/qird_pkg.sv
`default_nettype none

package qird_pkg;

  // Field widths of the stream items.
  localparam int DUR_W  = 16;
  localparam int TOL_W  = 4;
  localparam int CODE_W = 22;
  localparam int TGT_W  = 5;

  // Symbol pairs per frame, used as the default of the top level.
  localparam int SYMBOLS_DEFAULT = 11;

  // Tolerance after reset.
  localparam logic [TOL_W-1:0] TOL_RESET = 4'd3;

  // Nominal durations in ticks.
  localparam logic [TGT_W-1:0] SPACE_0     = 5'd11;
  localparam logic [TGT_W-1:0] SPACE_1     = 5'd17;
  localparam logic [TGT_W-1:0] SPACE_2     = 5'd23;
  localparam logic [TGT_W-1:0] SPACE_3     = 5'd29;
  localparam logic [TGT_W-1:0] DATA_MARK   = 5'd12;
  localparam logic [TGT_W-1:0] HEADER_MARK = 5'd21;

  // Symbol codes shifted into the frame code.
  typedef enum logic [1:0] {
    SYM_0 = 2'd0,
    SYM_1 = 2'd1,
    SYM_2 = 2'd2,
    SYM_3 = 2'd3
  } sym_t;

  // Result of one item as seen by the output register.
  typedef struct packed {
    logic              emit;
    logic              ok;
    logic [CODE_W-1:0] code;
  } frame_res_t;

  // True when d lies within target plus or minus tol; the low bound stops at zero.
  function automatic logic in_window(input logic [DUR_W-1:0] d,
                                     input logic [TGT_W-1:0] target,
                                     input logic [TOL_W-1:0] tol);
    logic [TGT_W:0] lo;
    logic [TGT_W:0] hi;
    lo = (target > TGT_W'(tol)) ? ({1'b0, target} - (TGT_W+1)'(tol)) : '0;
    hi = {1'b0, target} + (TGT_W+1)'(tol);
    return (d >= DUR_W'(lo)) && (d <= DUR_W'(hi));
  endfunction

endpackage

`default_nettype wire

// File: sv/qird_frame.sv
`default_nettype none

module qird_frame #(
  parameter int SYMBOLS = qird_pkg::SYMBOLS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [qird_pkg::DUR_W-1:0]  duration,
  input  wire logic                        last,
  input  wire logic [qird_pkg::TOL_W-1:0]  tolerance,
  output qird_pkg::frame_res_t             res
);
  import qird_pkg::*;

  localparam int FRAME_LEN = 2 * SYMBOLS + 2;
  localparam int POS_CAP   = FRAME_LEN + 1;
  localparam int POS_W     = $clog2(POS_CAP + 1);

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_END    = POS_W'(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_FINAL  = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_SAT    = POS_W'(POS_CAP);

  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  position_next;
  logic [CODE_W-1:0] shift_code;
  logic [CODE_W-1:0] shift_code_next;
  logic              failed;
  logic              failed_next;
  logic              good;
  sym_t              sym;
  logic              sym_hit;

  // Classify a space in priority order.
  always_comb begin
    sym_hit = 1'b1;
    if (in_window(duration, SPACE_0, tolerance)) begin
      sym = SYM_0;
    end else if (in_window(duration, SPACE_1, tolerance)) begin
      sym = SYM_1;
    end else if (in_window(duration, SPACE_2, tolerance)) begin
      sym = SYM_2;
    end else if (in_window(duration, SPACE_3, tolerance)) begin
      sym = SYM_3;
    end else begin
      sym     = SYM_0;
      sym_hit = 1'b0;
    end
  end

  // Frame state update for the current item.
  always_comb begin
    shift_code_next = shift_code;
    failed_next     = failed;
    if (position == POS_HEADER) begin
      if (!in_window(duration, HEADER_MARK, tolerance)) begin
        failed_next = 1'b1;
      end
    end else if (position >= POS_FIRST && position < POS_END) begin
      // Spaces sit at even positions, data marks at odd ones.
      if (!position[0]) begin
        shift_code_next = {shift_code[CODE_W-3:0], sym};
        if (!sym_hit) begin
          failed_next = 1'b1;
        end
      end else if (!in_window(duration, DATA_MARK, tolerance)) begin
        failed_next = 1'b1;
      end
    end else if (position >= POS_END) begin
      failed_next = 1'b1;
    end

    position_next = (position < POS_SAT) ? position + POS_W'(1) : position;
  end

  // Result of a last item.
  always_comb begin
    good     = !failed_next && (position == POS_FINAL);
    res.emit = en && last;
    res.ok   = good;
    res.code = good ? shift_code_next : '0;
  end

  // Frame state; a last item clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      shift_code <= '0;
      failed     <= 1'b0;
    end else if (en) begin
      if (last) begin
        position   <= '0;
        shift_code <= '0;
        failed     <= 1'b0;
      end else begin
        position   <= position_next;
        shift_code <= shift_code_next;
        failed     <= failed_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/quaternary_ir_frame_decoder.sv
`default_nettype none

// Quaternary pulse-distance IR frame decoder. Each input item is one measured
// mark or space duration in ticks, with tlast on the final duration of a frame.
// The decoder skips the leading gap, checks the header mark, then reads SYMBOLS
// space/mark pairs, each space giving a two-bit symbol (first symbol in the
// most significant bits). On the last item one result item is sent: tuser is ok
// and tdata is the code, zero when the frame is rejected. The decoder takes one
// item per clock while the result register is not stalled; a result leaves
// through the input register and the result register. The tolerance register
// is written through the cfg channel, which is always ready. The user must write
// it only while no frame is in flight; the block itself does not enforce this.
module quaternary_ir_frame_decoder #(
  parameter int SYMBOLS = qird_pkg::SYMBOLS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Tolerance register write
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [qird_pkg::TOL_W-1:0]  cfg_data,
  // Input items
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [15:0]                 s_tdata,   // [15:0] duration
  input  wire logic                        s_tlast,   // last duration of the frame
  // Result items
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [23:0]                 m_tdata,   // [21:0] code, [23:22] zero
  output      logic                        m_tuser    // [0] ok
);
  import qird_pkg::*;

  `include "quaternary_ir_frame_decoder_assert.svh"

  logic [TOL_W-1:0]  tolerance;
  logic              v1;
  logic [DUR_W-1:0]  dur1;
  logic              last1;
  logic              out_free;
  logic              move1;
  frame_res_t        res;
  logic              ok_reg;
  logic [CODE_W-1:0] code_reg;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  // Pipeline flow: the input register moves on when the result register is free.
  assign out_free = !m_tvalid || m_tready;
  assign move1    = v1 && out_free;
  assign s_tready = !v1 || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      dur1  <= s_tdata;
      last1 <= s_tlast;
    end
  end

  // Frame tracking and classification.
  qird_frame #(
    .SYMBOLS (SYMBOLS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .en        (move1),
    .duration  (dur1),
    .last      (last1),
    .tolerance (tolerance),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.emit) begin
      ok_reg   <= res.ok;
      code_reg <= res.code;
    end
  end

  assign m_tdata = {2'b00, code_reg};
  assign m_tuser = ok_reg;

  // Checks.
  `QIRD_ASSERT(a_reject_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata == '0,
               "rejected frame carries a nonzero code")
  `QIRD_ASSERT(a_result_after_last, clk, rst,
               $rose(m_tvalid) |-> $past(v1 && last1),
               "result item without a last duration")
  `QIRD_ASSERT(a_stage_hold, clk, rst,
               v1 && !out_free |=> v1 && $stable(dur1) && $stable(last1),
               "stalled input register lost its item")
  `QIRD_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready,
                      "configuration channel not ready")

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import qird_pkg::*;

  // Frame geometry for the default symbol count.
  localparam int FRAME_ITEMS = 2 * SYMBOLS_DEFAULT + 2;
  localparam int POS_SAT     = FRAME_ITEMS + 1;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_MISSES = 10;

  // One row of the directed stimulus; typed rows carry their own expected result.
  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic              last;
    logic              typed;
    logic              ok;
    logic [CODE_W-1:0] code;
  } dir_row_t;

  // A single-item frame, then a full good frame at tolerance 3 that walks the
  // window edges and the places where neighboring symbol windows overlap.
  localparam dir_row_t DIRECTED_ROWS [25] = '{
    '{16'd0,     1'b1, 1'b1, 1'b0, 22'd0},
    '{16'd65535, 1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd24,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd8,     1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd9,     1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd14,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd15,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd20,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd26,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd32,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd17,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd23,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd29,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd11,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd29,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd23,    1'b0, 1'b0, 1'b0, 22'd0},
    '{16'd12,    1'b1, 1'b0, 1'b0, 22'd0}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TOL_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              m_tuser;

  // Decoder state mirrored by the testbench.
  logic [4:0]        dec_pos;
  logic [CODE_W-1:0] dec_code;
  logic              dec_bad;
  logic [TOL_W-1:0]  dec_tol;

  frame_res_t        pending_frames [$];
  int unsigned       mismatches = 0;
  int unsigned       fed_items = 0;
  int unsigned       cycles = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       hold_req = 0;
  int unsigned       hold_ack = 0;
  int unsigned       hold_left = 0;

  quaternary_ir_frame_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // True when d lies within the current tolerance of center; the low bound stops at zero.
  function automatic bit hits(input logic [DUR_W-1:0] d, input logic [TGT_W-1:0] center);
    int lo;
    int hi;
    lo = int'(center) - int'(dec_tol);
    if (lo < 0) lo = 0;
    hi = int'(center) + int'(dec_tol);
    return int'(d) >= lo && int'(d) <= hi;
  endfunction

  // Advances the mirrored state by one duration and returns the result it causes.
  function automatic frame_res_t decode_step(input logic [DUR_W-1:0] d, input bit last);
    frame_res_t r;
    sym_t       s;
    r = '0;
    if (dec_pos == 5'd1) begin
      if (!hits(d, HEADER_MARK)) dec_bad = 1'b1;
    end else if (dec_pos >= 2 && dec_pos < FRAME_ITEMS) begin
      // Even positions are spaces, odd ones data marks.
      if (!dec_pos[0]) begin
        if (hits(d, SPACE_0)) s = SYM_0;
        else if (hits(d, SPACE_1)) s = SYM_1;
        else if (hits(d, SPACE_2)) s = SYM_2;
        else if (hits(d, SPACE_3)) s = SYM_3;
        else begin
          s = SYM_0;
          dec_bad = 1'b1;
        end
        dec_code = {dec_code[CODE_W-3:0], s};
      end else if (!hits(d, DATA_MARK)) begin
        dec_bad = 1'b1;
      end
    end else if (dec_pos >= FRAME_ITEMS) begin
      dec_bad = 1'b1;
    end
    r.emit = last;
    r.ok   = last && !dec_bad && dec_pos == FRAME_ITEMS - 1;
    r.code = r.ok ? dec_code : '0;
    if (dec_pos < POS_SAT) dec_pos = dec_pos + 5'd1;
    if (last) begin
      dec_pos  = '0;
      dec_code = '0;
      dec_bad  = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [TGT_W-1:0] space_target(input sym_t s);
    case (s)
      SYM_0: return SPACE_0;
      SYM_1: return SPACE_1;
      SYM_2: return SPACE_2;
      default: return SPACE_3;
    endcase
  endfunction

  // A duration somewhere inside the window of center.
  function automatic int unsigned near(input logic [TGT_W-1:0] center);
    int v;
    v = int'(center) - int'(dec_tol) + int'($urandom_range(0, 2 * dec_tol));
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic void note_miss(input string what, input logic [CODE_W-1:0] want,
                                    input logic [CODE_W-1:0] got);
    mismatches++;
    if (mismatches <= SHOWN_MISSES)
      $display("%0t: %s mismatch, expected 0x%06h, got 0x%06h", $realtime, what, want, got);
  endfunction

  // Offers one item, honoring the sender idle rate, and predicts on acceptance.
  task automatic send_item(input logic [DUR_W-1:0] dur, input bit last, input bit typed,
                           input bit t_ok, input logic [CODE_W-1:0] t_code);
    frame_res_t r;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= dur;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fed_items++;
    r = decode_step(dur, last);
    if (r.emit) begin
      if (typed) begin
        r.ok   = t_ok;
        r.code = t_code;
      end
      pending_frames.push_back(r);
    end
  endtask

  // Mostly well-formed frames with random symbols, the rest damaged or noise.
  task automatic send_frame();
    int unsigned durs [$];
    int unsigned pick;
    int unsigned spot;
    int unsigned cut;
    sym_t        s;
    pick = $urandom_range(0, 99);
    if (pick >= 88) begin
      repeat ($urandom_range(1, 6)) durs.push_back($urandom_range(0, 65535));
    end else begin
      durs.push_back($urandom_range(0, 65535));
      durs.push_back(near(HEADER_MARK));
      repeat (SYMBOLS_DEFAULT) begin
        s = sym_t'($urandom_range(0, 3));
        durs.push_back(near(space_target(s)));
        durs.push_back(near(DATA_MARK));
      end
      if (pick >= 70 && pick < 80) begin
        // One duration replaced, often close to the windows.
        spot = $urandom_range(1, FRAME_ITEMS - 1);
        durs[spot] = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 48);
      end else if (pick >= 80) begin
        if ($urandom_range(0, 1)) begin
          cut = $urandom_range(0, FRAME_ITEMS - 2);
          durs = durs[0:cut];
        end else begin
          repeat ($urandom_range(1, 12)) durs.push_back(near(DATA_MARK));
        end
      end
    end
    foreach (durs[i]) send_item(durs[i][DUR_W-1:0], i == durs.size() - 1, 1'b0, 1'b0, '0);
  endtask

  // Drops valid and waits until every expected result is out and the pipe is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dec_tol = value;
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack  = hold_req;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_pct != 0) begin
      m_tready <= $urandom_range(0, 99) >= stall_pct;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    frame_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        note_miss("unexpected result", '0, m_tdata[CODE_W-1:0]);
      end else begin
        want = pending_frames.pop_front();
        if (m_tuser !== want.ok) note_miss("ok", want.ok, m_tuser);
        if (m_tdata[CODE_W-1:0] !== want.code) note_miss("code", want.code, m_tdata[CODE_W-1:0]);
        if (m_tdata[23:CODE_W] !== '0) note_miss("padding", '0, m_tdata[23:CODE_W]);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("quaternary_ir_frame_decoder verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_tol [5];
    int unsigned phase_mode [5];
    int unsigned target;
    dec_pos  = '0;
    dec_code = '0;
    dec_bad  = 1'b0;
    dec_tol  = TOL_RESET;
    phase_tol  = '{0, 10, 15, 0, 3};
    phase_mode = '{0, 1, 2, 3, 0};
    phase_tol[3] = $urandom_range(1, 9);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset tolerance.
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].dur, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].ok, DIRECTED_ROWS[i].code);
    drain();

    // Random phases, each with its own tolerance and idle pattern.
    fed_items = 0;
    foreach (phase_tol[p]) begin
      write_tolerance(phase_tol[p][TOL_W-1:0]);
      case (phase_mode[p])
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        3: begin idle_pct = 36; stall_pct = 36; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      // Back-pressure test: results held off while frames keep coming.
      if (p == 0) hold_req <= hold_req + 1;
      target = fed_items + ITEMS_PER_PHASE;
      while (fed_items < target) send_frame();
      drain();
    end

    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("quaternary_ir_frame_decoder verification clean");
    end else begin
      $display("quaternary_ir_frame_decoder verification failed");
    end
    $finish;
  end

endmodule
